>>> sv/mecanum_wheel_mixer_defines.svh
// assertion helpers for the wheel mixer
`ifndef MECANUM_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mixer check failed");

// next-cycle implication, checked outside reset
`define MWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mixer check failed");

`endif

>>> sv/mwm_pkg.sv
package mwm_pkg;

	localparam int IN_W   = 16;
	localparam int OUT_W  = 16;
	localparam int SUM_W  = 18;
	localparam int MAG_W  = 17;
	localparam int WHEELS = 4;

	// wheel order in every per-wheel array and in the output item
	localparam int FL = 0;
	localparam int FR = 1;
	localparam int RL = 2;
	localparam int RR = 3;

	typedef logic signed [IN_W-1:0]  cmd_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic        [MAG_W-1:0] mag_t;
	typedef logic        [SUM_W-1:0] rem_t;

endpackage

>>> sv/mecanum_wheel_mixer.sv
// mecanum wheel mixer
// input channel s_axis: one item holds strafe, forward and rotate commands,
// signed fixed point with 1.0 = 2**FRACTION_BITS. each command is clamped
// to +/-1.0 and mixed into front left, front right, rear left, rear right.
// when the largest wheel magnitude exceeds 1.0 all four are scaled down by
// it (quotient truncated toward zero).
// output channel m_axis: one item of four wheel speeds per input item.
// pipeline from the accepting edge to m_axis_tvalid: clamp, mix, max,
// FRACTION_BITS + 1 divider stages, output register.
// throughput: one item per cycle unless the receiver stalls; the pipelined
// divider retires one quotient bit per stage for all four wheels in parallel.
// reset clears every stage valid bit; the pipeline is empty afterwards.
// when the receiver stalls the whole pipeline holds, s_axis_tready drops
// and no item is lost or repeated.
module mecanum_wheel_mixer #(
	parameter int FRACTION_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// strafe_cmd [15:0], forward_cmd [31:16], rotate_cmd [47:32]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// front_left_speed [15:0], front_right_speed [31:16],
	// rear_left_speed [47:32], rear_right_speed [63:48]
	output logic [63:0] m_axis_tdata
);

`include "mecanum_wheel_mixer_defines.svh"

	localparam int DS = FRACTION_BITS + 1;
	localparam int QW = FRACTION_BITS + 1;
	localparam int XW = (QW + 1 > mwm_pkg::OUT_W) ? QW + 1 : mwm_pkg::OUT_W;
	localparam logic signed [32:0] UNIT = 33'sd1 <<< FRACTION_BITS;

	function automatic mwm_pkg::cmd_t clamp_unit(input mwm_pkg::cmd_t v);
		logic signed [32:0] x;
		logic signed [32:0] nu;
		x  = 33'(v);
		nu = -UNIT;
		if (x > UNIT) return mwm_pkg::cmd_t'(UNIT[mwm_pkg::IN_W-1:0]);
		if (x < nu) return mwm_pkg::cmd_t'(nu[mwm_pkg::IN_W-1:0]);
		return v;
	endfunction

	function automatic mwm_pkg::mag_t mag_of(input mwm_pkg::sum_t v);
		mwm_pkg::sum_t n;
		n = -v;
		return v[mwm_pkg::SUM_W-1] ? n[mwm_pkg::MAG_W-1:0] : v[mwm_pkg::MAG_W-1:0];
	endfunction

	logic en;
	logic out_valid_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_valid_q;

	// stage 1: clamp
	logic         v_s1;
	mwm_pkg::cmd_t st_s1, fw_s1, rt_s1;

	// stage 2: mix and magnitudes
	logic         v_s2;
	mwm_pkg::sum_t sum_s2 [mwm_pkg::WHEELS];
	mwm_pkg::mag_t mag_s2 [mwm_pkg::WHEELS];

	// divider stages, index 0 is stage 3 (largest magnitude found)
	logic          dv_valid_s [0:DS];
	logic          dv_scl_s   [0:DS];
	mwm_pkg::mag_t dv_lrg_s   [0:DS];
	mwm_pkg::sum_t dv_sum_s   [0:DS][mwm_pkg::WHEELS];
	mwm_pkg::rem_t dv_rem_s   [0:DS][mwm_pkg::WHEELS];
	logic [QW-1:0] dv_quo_s   [0:DS][mwm_pkg::WHEELS];

	mwm_pkg::rem_t nxt_rem [0:DS-1][mwm_pkg::WHEELS];
	logic          nxt_ge  [0:DS-1][mwm_pkg::WHEELS];

	mwm_pkg::mag_t max01, max23, lrg;

	always_comb begin
		max01 = (mag_s2[mwm_pkg::FR] > mag_s2[mwm_pkg::FL]) ?
			mag_s2[mwm_pkg::FR] : mag_s2[mwm_pkg::FL];
		max23 = (mag_s2[mwm_pkg::RR] > mag_s2[mwm_pkg::RL]) ?
			mag_s2[mwm_pkg::RR] : mag_s2[mwm_pkg::RL];
		lrg   = (max23 > max01) ? max23 : max01;
	end

	// restoring division: the first stage tests the 2**FRACTION_BITS bit
	always_comb begin
		for (int k = 0; k < DS; k++) begin
			for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
				mwm_pkg::rem_t r_in;
				r_in = (k == 0) ? dv_rem_s[k][w] :
					{dv_rem_s[k][w][mwm_pkg::SUM_W-2:0], 1'b0};
				nxt_ge[k][w]  = r_in >= {1'b0, dv_lrg_s[k]};
				nxt_rem[k][w] = nxt_ge[k][w] ? r_in - {1'b0, dv_lrg_s[k]} : r_in;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= DS; k++) dv_valid_s[k] <= 1'b0;
		end else if (en) begin
			v_s1          <= s_axis_tvalid;
			v_s2          <= v_s1;
			dv_valid_s[0] <= v_s2;
			for (int k = 1; k <= DS; k++) dv_valid_s[k] <= dv_valid_s[k-1];
			out_valid_q   <= dv_valid_s[DS];
		end
	end

	logic [mwm_pkg::OUT_W-1:0] spd [mwm_pkg::WHEELS];

	always_comb begin
		for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
			logic signed [XW-1:0] qx;
			logic signed [XW-1:0] qv;
			qx = XW'(dv_quo_s[DS][w]);
			qv = dv_sum_s[DS][w][mwm_pkg::SUM_W-1] ? -qx : qx;
			spd[w] = dv_scl_s[DS] ? qv[mwm_pkg::OUT_W-1:0] :
				dv_sum_s[DS][w][mwm_pkg::OUT_W-1:0];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= clamp_unit(s_axis_tdata[15:0]);
			fw_s1 <= clamp_unit(s_axis_tdata[31:16]);
			rt_s1 <= clamp_unit(s_axis_tdata[47:32]);

			sum_s2[mwm_pkg::FL] <= mwm_pkg::sum_t'(st_s1) + mwm_pkg::sum_t'(fw_s1)
				+ mwm_pkg::sum_t'(rt_s1);
			sum_s2[mwm_pkg::FR] <= mwm_pkg::sum_t'(st_s1) - mwm_pkg::sum_t'(fw_s1)
				- mwm_pkg::sum_t'(rt_s1);
			sum_s2[mwm_pkg::RL] <= mwm_pkg::sum_t'(st_s1) - mwm_pkg::sum_t'(fw_s1)
				+ mwm_pkg::sum_t'(rt_s1);
			sum_s2[mwm_pkg::RR] <= mwm_pkg::sum_t'(st_s1) + mwm_pkg::sum_t'(fw_s1)
				- mwm_pkg::sum_t'(rt_s1);
			mag_s2[mwm_pkg::FL] <= mag_of(mwm_pkg::sum_t'(st_s1) + mwm_pkg::sum_t'(fw_s1)
				+ mwm_pkg::sum_t'(rt_s1));
			mag_s2[mwm_pkg::FR] <= mag_of(mwm_pkg::sum_t'(st_s1) - mwm_pkg::sum_t'(fw_s1)
				- mwm_pkg::sum_t'(rt_s1));
			mag_s2[mwm_pkg::RL] <= mag_of(mwm_pkg::sum_t'(st_s1) - mwm_pkg::sum_t'(fw_s1)
				+ mwm_pkg::sum_t'(rt_s1));
			mag_s2[mwm_pkg::RR] <= mag_of(mwm_pkg::sum_t'(st_s1) + mwm_pkg::sum_t'(fw_s1)
				- mwm_pkg::sum_t'(rt_s1));

			dv_lrg_s[0] <= lrg;
			dv_scl_s[0] <= $signed({16'b0, lrg}) > UNIT;
			for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
				dv_sum_s[0][w] <= sum_s2[w];
				dv_rem_s[0][w] <= {1'b0, mag_s2[w]};
				dv_quo_s[0][w] <= '0;
			end

			for (int k = 1; k <= DS; k++) begin
				dv_lrg_s[k] <= dv_lrg_s[k-1];
				dv_scl_s[k] <= dv_scl_s[k-1];
				for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
					dv_sum_s[k][w] <= dv_sum_s[k-1][w];
					dv_rem_s[k][w] <= nxt_rem[k-1][w];
					dv_quo_s[k][w] <= {dv_quo_s[k-1][w][QW-2:0], nxt_ge[k-1][w]};
				end
			end

			m_axis_tdata <= {spd[mwm_pkg::RR], spd[mwm_pkg::RL],
				spd[mwm_pkg::FR], spd[mwm_pkg::FL]};
		end
	end

	// checks
	logic out_in_range;
	logic rem_below;

	always_comb begin
		logic signed [32:0] x;
		out_in_range = 1'b1;
		for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
			x = 33'($signed(m_axis_tdata[w*mwm_pkg::OUT_W +: mwm_pkg::OUT_W]));
			if (x > UNIT || x < -UNIT) out_in_range = 1'b0;
		end
		rem_below = 1'b1;
		for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
			if (dv_rem_s[DS][w] >= {1'b0, dv_lrg_s[DS]}) rem_below = 1'b0;
		end
	end

	`MWM_ASSERT_NXT(a_accept_enters, clk, arst_n, s_axis_tvalid && s_axis_tready, v_s1)
	`MWM_ASSERT_IMP(a_rem_below_largest, clk, arst_n, dv_valid_s[DS] && dv_scl_s[DS], rem_below)
	`MWM_ASSERT_IMP(a_speed_in_range, clk, arst_n, m_axis_tvalid && (FRACTION_BITS <= 14), out_in_range)
	`MWM_ASSERT_NXT(a_stall_holds_stage, clk, arst_n, dv_valid_s[DS] && !en, dv_valid_s[DS])

endmodule

>>> verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS   = 14;
	localparam int LATENCY     = FRAC_BITS + 5;
	localparam int RANDOM_CMDS = 1830;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 2000;
	localparam int SHOW_MAX    = 10;

	typedef struct {
		int s;
		int f;
		int r;
		bit known;
		int fl;
		int fr;
		int rl;
		int rr;
	} dir_row_t;

	// hand-checked rows carry their wheel speeds, the rest go through mix_wheels
	localparam int DIR_ROWS = 22;
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{      0,      0,      0, 1,      0,      0,      0,      0},
		'{  16384,      0,      0, 1,  16384,  16384,  16384,  16384},
		'{      0,  16384,      0, 1,  16384, -16384, -16384,  16384},
		'{      0,      0,  16384, 1,  16384, -16384,  16384, -16384},
		'{  32767,      0,      0, 1,  16384,  16384,  16384,  16384},
		'{ -32768,      0,      0, 1, -16384, -16384, -16384, -16384},
		'{      0, -32768,      0, 1, -16384,  16384,  16384, -16384},
		'{      0,      0,  32767, 1,  16384, -16384,  16384, -16384},
		'{  16383,      0,      0, 1,  16383,  16383,  16383,  16383},
		'{  16385,      0,      0, 1,  16384,  16384,  16384,  16384},
		'{  16384,  16384,  16384, 1,  16384,  -5461,   5461,   5461},
		'{ -32768, -32768, -32768, 1, -16384,   5461,  -5461,  -5461},
		'{  32767,  32767,  32767, 1,  16384,  -5461,   5461,   5461},
		'{   8192,   8192,      0, 1,  16384,      0,      0,  16384},
		'{  16384,  16384,      0, 1,  16384,      0,      0,  16384},
		'{  16384, -16384,      0, 1,      0,  16384,  16384,      0},
		'{   8192,   8192,      1, 0,      0,      0,      0,      0},
		'{      1,     -1,      1, 0,      0,      0,      0,      0},
		'{     -1,     -1,     -1, 0,      0,      0,      0,      0},
		'{  12345,  -6789,   3000, 0,      0,      0,      0,      0},
		'{ -32768,  32767,      1, 0,      0,      0,      0,      0},
		'{   9999,  -7777,  11111, 0,      0,      0,      0,      0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// strafe_cmd [15:0], forward_cmd [31:16], rotate_cmd [47:32]
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// front_left_speed [15:0], front_right_speed [31:16],
	// rear_left_speed [47:32], rear_right_speed [63:48]
	logic [63:0] m_axis_tdata;

	logic [63:0] wheel_speeds_due [$];
	logic [63:0] due_word;
	int          miss_count = 0;
	int          idle_ticks = 0;
	bit          steady     = 0;
	bit          hold_req   = 0;

	mecanum_wheel_mixer #(
		.FRACTION_BITS(FRAC_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint clamp_cmd(input mwm_pkg::cmd_t v, input longint unit);
		longint x;
		x = longint'(v);
		if (x > unit) return unit;
		if (x < -unit) return -unit;
		return x;
	endfunction

	// four wheel speeds packed as on m_axis_tdata
	function automatic logic [63:0] mix_wheels(input mwm_pkg::cmd_t s_in,
		input mwm_pkg::cmd_t f_in, input mwm_pkg::cmd_t r_in);
		longint      unit;
		longint      s;
		longint      f;
		longint      r;
		longint      peak;
		longint      mag;
		longint      wheel [mwm_pkg::WHEELS];
		logic [63:0] word;
		unit = longint'(1) << FRAC_BITS;
		s = clamp_cmd(s_in, unit);
		f = clamp_cmd(f_in, unit);
		r = clamp_cmd(r_in, unit);
		wheel[mwm_pkg::FL] = s + f + r;
		wheel[mwm_pkg::FR] = s - f - r;
		wheel[mwm_pkg::RL] = s - f + r;
		wheel[mwm_pkg::RR] = s + f - r;
		peak = 0;
		for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
			mag = (wheel[w] < 0) ? -wheel[w] : wheel[w];
			if (mag > peak) peak = mag;
		end
		// scale so the strongest wheel reads exactly 1.0, quotient toward zero
		if (peak > unit) begin
			for (int w = 0; w < mwm_pkg::WHEELS; w++) wheel[w] = (wheel[w] * unit) / peak;
		end
		for (int w = 0; w < mwm_pkg::WHEELS; w++)
			word[w*mwm_pkg::OUT_W +: mwm_pkg::OUT_W] = wheel[w][mwm_pkg::OUT_W-1:0];
		return word;
	endfunction

	function automatic mwm_pkg::cmd_t rand_cmd();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50) return mwm_pkg::cmd_t'(int'($urandom_range(32768)) - 16384);
		if (pick < 80) return mwm_pkg::cmd_t'($urandom());
		if (pick < 90) return mwm_pkg::cmd_t'(int'($urandom_range(128)) - 64);
		case ($urandom_range(5))
			0: return mwm_pkg::cmd_t'(16384);
			1: return mwm_pkg::cmd_t'(-16384);
			2: return mwm_pkg::cmd_t'(16383);
			3: return mwm_pkg::cmd_t'(-16385);
			4: return mwm_pkg::cmd_t'(32767);
			default: return mwm_pkg::cmd_t'(-32768);
		endcase
	endfunction

	task automatic push_cmd(input mwm_pkg::cmd_t s, input mwm_pkg::cmd_t f,
		input mwm_pkg::cmd_t r, input bit known, input logic [63:0] known_word);
		while (!steady && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r, f, s};
		do @(posedge clk); while (!s_axis_tready);
		wheel_speeds_due.push_back(known ? known_word : mix_wheels(s, f, r));
	endtask

	task automatic note_miss(input string what, input logic [63:0] want,
		input logic [63:0] got);
		miss_count++;
		if (miss_count <= SHOW_MAX)
			$display("tb: mismatch %s expected %h actual %h", what, want, got);
	endtask

	// result side: compare each item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (wheel_speeds_due.size() == 0) begin
				note_miss("unexpected item", 64'h0, m_axis_tdata);
			end else begin
				due_word = wheel_speeds_due.pop_front();
				for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
					if (m_axis_tdata[w*mwm_pkg::OUT_W +: mwm_pkg::OUT_W] !==
						due_word[w*mwm_pkg::OUT_W +: mwm_pkg::OUT_W])
						note_miss($sformatf("wheel %0d", w),
							due_word[w*mwm_pkg::OUT_W +: mwm_pkg::OUT_W],
							m_axis_tdata[w*mwm_pkg::OUT_W +: mwm_pkg::OUT_W]);
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_ticks <= 0;
			end else if (idle_ticks >= STALL_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end else begin
				idle_ticks <= idle_ticks + 1;
			end
		end
	end

	// receiver: random stalls, a calm window and one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 12);
			end
		end
	end

	initial begin
		dir_row_t row;
		logic [63:0] word;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row  = dir_rows[i];
			word = {row.rr[mwm_pkg::OUT_W-1:0], row.rl[mwm_pkg::OUT_W-1:0],
				row.fr[mwm_pkg::OUT_W-1:0], row.fl[mwm_pkg::OUT_W-1:0]};
			push_cmd(mwm_pkg::cmd_t'(row.s), mwm_pkg::cmd_t'(row.f),
				mwm_pkg::cmd_t'(row.r), row.known, word);
		end

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			if (i == 400) hold_req = 1;
			steady = (i >= 900 && i < 1200);
			if (i == 1300) begin
				// let the pipeline run dry before going on
				s_axis_tvalid <= 1'b0;
				while (wheel_speeds_due.size() != 0) @(posedge clk);
			end
			push_cmd(rand_cmd(), rand_cmd(), rand_cmd(), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		steady = 0;

		while (wheel_speeds_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (miss_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/mwm_pkg.sv
sv/mecanum_wheel_mixer.sv
verif/tb.sv
